// File: rtl/core/pi2d_pkg.sv
`timescale 1ns / 1ps

package pi2d_pkg;

	localparam int CW  = 16;
	localparam int DW  = CW + 1;
	localparam int EW  = CW + 2;
	localparam int PW  = 2 * EW;
	localparam int SW  = PW + 1;
	localparam int CRW = 2 * CW + 2;
	localparam int LW  = CRW / 2 + 1;
	localparam int HW  = CRW - LW;
	localparam int QW  = 2 * CW + 1;
	localparam int R2W = 2 * CW - 1;
	localparam int XW  = 2 * CRW;
	localparam int QD  = 2;
	localparam int QAW = $clog2(QD);

	typedef enum logic [2:0] {
		OP_PT_CIRC,
		OP_PT_RECT,
		OP_SEG_CIRC,
		OP_SEG_RECT,
		OP_CIRC_CIRC,
		OP_CIRC_RECT,
		OP_RECT_RECT,
		OP_UNUSED
	} op_t;

	typedef struct packed {
		op_t                   opcode;
		logic signed [CW-1:0]  a_x;
		logic signed [CW-1:0]  a_y;
		logic signed [CW-1:0]  a_w;
		logic signed [CW-1:0]  a_h;
		logic signed [CW-1:0]  b_x;
		logic signed [CW-1:0]  b_y;
		logic signed [CW-1:0]  b_w;
		logic signed [CW-1:0]  b_h;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic bad_opcode;
	} out_item_t;

	// classified query as it waits in the queue
	typedef struct packed {
		op_t                   op;
		logic                  quick;
		logic signed [DW-1:0]  ax;
		logic signed [DW-1:0]  ay;
		logic signed [DW-1:0]  aw;
		logic signed [DW-1:0]  bw;
		logic signed [DW-1:0]  dx0;
		logic signed [DW-1:0]  dy0;
		logic signed [DW-1:0]  rs;
		logic signed [DW-1:0]  sdx;
		logic signed [DW-1:0]  sdy;
		logic signed [DW-1:0]  wx;
		logic signed [DW-1:0]  wy;
		logic signed [DW-1:0]  ux;
		logic signed [DW-1:0]  uy;
		logic signed [DW-1:0]  bx0;
		logic signed [DW-1:0]  bx1;
		logic signed [DW-1:0]  by0;
		logic signed [DW-1:0]  by1;
	} ft_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

	function automatic logic signed [EW-1:0] sx1(input logic signed [DW-1:0] v);
		return {v[DW-1], v};
	endfunction

endpackage

// File: rtl/core/pi2d_front.sv
`timescale 1ns / 1ps

module pi2d_front import pi2d_pkg::*; (
	input  in_item_t in_data,
	output ft_t      f
);

	logic signed [DW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
	logic signed [DW-1:0] ex, ey, fx, fy;
	logic signed [DW-1:0] ax0, ax1, ay0, ay1;
	logic in_box, overlap;

	always_comb begin
		ax = sx(in_data.a_x);
		ay = sx(in_data.a_y);
		aw = sx(in_data.a_w);
		ah = sx(in_data.a_h);
		bx = sx(in_data.b_x);
		by = sx(in_data.b_y);
		bw = sx(in_data.b_w);
		bh = sx(in_data.b_h);

		// spans, low end first
		ex = bx + bw;
		ey = by + bh;
		fx = ax + aw;
		fy = ay + ah;
		f.bx0 = in_data.b_w[CW-1] ? ex : bx;
		f.bx1 = in_data.b_w[CW-1] ? bx : ex;
		f.by0 = in_data.b_h[CW-1] ? ey : by;
		f.by1 = in_data.b_h[CW-1] ? by : ey;
		ax0 = in_data.a_w[CW-1] ? fx : ax;
		ax1 = in_data.a_w[CW-1] ? ax : fx;
		ay0 = in_data.a_h[CW-1] ? fy : ay;
		ay1 = in_data.a_h[CW-1] ? ay : fy;

		in_box = (f.bx0 <= ax) && (ax <= f.bx1) && (f.by0 <= ay) && (ay <= f.by1);
		overlap = (f.bx0 <= ax1) && (ax0 <= f.bx1) && (f.by0 <= ay1) && (ay0 <= f.by1);

		f.op = in_data.opcode;
		case (in_data.opcode)
			OP_PT_RECT:   f.quick = in_box;
			OP_RECT_RECT: f.quick = overlap;
			default:      f.quick = 1'b0;
		endcase
		f.ax  = ax;
		f.ay  = ay;
		f.aw  = aw;
		f.bw  = bw;
		f.dx0 = ax - bx;
		f.dy0 = ay - by;
		f.rs  = aw + bw;
		f.sdx = aw - ax;
		f.sdy = ah - ay;
		f.wx  = bx - ax;
		f.wy  = by - ay;
		f.ux  = bx - aw;
		f.uy  = by - ah;
	end

endmodule

// File: rtl/core/pi2d_queue.sv
`timescale 1ns / 1ps

module pi2d_queue import pi2d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ft_t       wdata,
	input  logic      pop,
	output ft_t       rdata,
	output q_status_t qs
);

	ft_t              mem_q [QD];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     count_q;

	assign rdata    = mem_q[rd_ptr_q];
	assign qs.full  = (count_q == (QAW+1)'(QD));
	assign qs.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/core/pi2d_back.sv
`timescale 1ns / 1ps

module pi2d_back import pi2d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ft_t       f,
	input  q_status_t qs,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	typedef struct packed {
		op_t                  op;
		logic                 quick;
		logic                 okx;
		logic                 oky;
		logic                 par;
		logic signed [EW-1:0] qa;
		logic signed [EW-1:0] qb;
		logic signed [DW-1:0] r;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [DW-1:0] ux;
		logic signed [DW-1:0] uy;
		logic signed [EW-1:0] enx;
		logic signed [EW-1:0] exx;
		logic signed [EW-1:0] eny;
		logic signed [EW-1:0] exy;
		logic signed [DW-1:0] adx;
		logic signed [DW-1:0] ady;
	} s1_t;

	typedef struct packed {
		op_t                  op;
		logic                 quick;
		logic                 okx;
		logic                 oky;
		logic                 par;
		logic signed [PW-1:0] pqa;
		logic signed [PW-1:0] pqb;
		logic signed [PW-1:0] pr;
		logic signed [PW-1:0] pdd;
		logic signed [PW-1:0] pee;
		logic signed [PW-1:0] pux;
		logic signed [PW-1:0] puy;
		logic signed [PW-1:0] pp1;
		logic signed [PW-1:0] pp2;
		logic signed [PW-1:0] pc1;
		logic signed [PW-1:0] pc2;
		logic signed [PW-1:0] k1;
		logic signed [PW-1:0] k2;
		logic signed [PW-1:0] k3;
		logic signed [PW-1:0] k4;
	} s2_t;

	typedef struct packed {
		logic                  hit;
		logic                  bad;
		logic                  defer;
		logic signed [CRW-1:0] cr;
		logic [R2W-1:0]        r2;
		logic [QW-1:0]         q;
	} s3_t;

	typedef struct packed {
		logic                       hit;
		logic                       bad;
		logic                       defer;
		logic signed [2*HW-1:0]     hh;
		logic signed [HW+LW:0]      hl;
		logic [2*LW-1:0]            ll;
		logic [R2W+LW-1:0]          rql;
		logic [R2W+QW-LW-1:0]       rqh;
	} s4_t;

	s1_t n1, st_s1;
	s2_t n2, st_s2;
	s3_t n3, st_s3;
	s4_t n4, st_s4;
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	out_item_t out_data_q, n_out;
	logic adv;

	logic signed [DW-1:0] px, py, adx, ady;
	logic signed [EW-1:0] ex5, ey5, enx, exx, eny, exy;
	logic parx, pary;

	logic signed [SW-1:0] d2, r2, q, p, de, cr;
	logic signed [HW-1:0] hi_c;
	logic [LW-1:0]        lo_c;
	logic [XW-1:0]        cr2, rq;

	assign adv       = !out_valid_q || out_ready;
	assign pop       = adv && !qs.empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// clamp, slab setup, operand selection
	always_comb begin
		px = (f.ax < f.bx0) ? f.bx0 : ((f.ax > f.bx1) ? f.bx1 : f.ax);
		py = (f.ay < f.by0) ? f.by0 : ((f.ay > f.by1) ? f.by1 : f.ay);
		ex5 = sx1(f.ax) - sx1(px);
		ey5 = sx1(f.ay) - sx1(py);

		parx = (f.sdx == '0);
		pary = (f.sdy == '0);
		if (!f.sdx[DW-1] && !parx) begin
			enx = sx1(f.bx0) - sx1(f.ax);
			exx = sx1(f.bx1) - sx1(f.ax);
		end else begin
			enx = sx1(f.ax) - sx1(f.bx1);
			exx = sx1(f.ax) - sx1(f.bx0);
		end
		if (!f.sdy[DW-1] && !pary) begin
			eny = sx1(f.by0) - sx1(f.ay);
			exy = sx1(f.by1) - sx1(f.ay);
		end else begin
			eny = sx1(f.ay) - sx1(f.by1);
			exy = sx1(f.ay) - sx1(f.by0);
		end
		adx = f.sdx[DW-1] ? -f.sdx : f.sdx;
		ady = f.sdy[DW-1] ? -f.sdy : f.sdy;

		n1.op    = f.op;
		n1.quick = f.quick;
		n1.okx   = parx ? ((f.bx0 <= f.ax) && (f.ax <= f.bx1))
			: (!exx[EW-1] && (enx <= sx1(adx)));
		n1.oky   = pary ? ((f.by0 <= f.ay) && (f.ay <= f.by1))
			: (!exy[EW-1] && (eny <= sx1(ady)));
		n1.par   = parx || pary;
		n1.enx   = enx;
		n1.exx   = exx;
		n1.eny   = eny;
		n1.exy   = exy;
		n1.adx   = adx;
		n1.ady   = ady;
		n1.dx    = f.sdx;
		n1.dy    = f.sdy;
		n1.ux    = f.ux;
		n1.uy    = f.uy;
		case (f.op)
			OP_CIRC_RECT: begin
				n1.qa = ex5;
				n1.qb = ey5;
			end
			OP_SEG_CIRC: begin
				n1.qa = sx1(f.wx);
				n1.qb = sx1(f.wy);
			end
			default: begin
				n1.qa = sx1(f.dx0);
				n1.qb = sx1(f.dy0);
			end
		endcase
		case (f.op)
			OP_CIRC_CIRC: n1.r = f.rs;
			OP_CIRC_RECT: n1.r = f.aw;
			default:      n1.r = f.bw;
		endcase
	end

	// products
	always_comb begin
		n2.op    = st_s1.op;
		n2.quick = st_s1.quick;
		n2.okx   = st_s1.okx;
		n2.oky   = st_s1.oky;
		n2.par   = st_s1.par;
		n2.pqa   = PW'(st_s1.qa) * PW'(st_s1.qa);
		n2.pqb   = PW'(st_s1.qb) * PW'(st_s1.qb);
		n2.pr    = PW'(st_s1.r) * PW'(st_s1.r);
		n2.pdd   = PW'(st_s1.dx) * PW'(st_s1.dx);
		n2.pee   = PW'(st_s1.dy) * PW'(st_s1.dy);
		n2.pux   = PW'(st_s1.ux) * PW'(st_s1.ux);
		n2.puy   = PW'(st_s1.uy) * PW'(st_s1.uy);
		n2.pp1   = PW'(st_s1.qa) * PW'(st_s1.dx);
		n2.pp2   = PW'(st_s1.qb) * PW'(st_s1.dy);
		n2.pc1   = PW'(st_s1.qa) * PW'(st_s1.dy);
		n2.pc2   = PW'(st_s1.qb) * PW'(st_s1.dx);
		n2.k1    = PW'(st_s1.enx) * PW'(st_s1.ady);
		n2.k2    = PW'(st_s1.exy) * PW'(st_s1.adx);
		n2.k3    = PW'(st_s1.eny) * PW'(st_s1.adx);
		n2.k4    = PW'(st_s1.exx) * PW'(st_s1.ady);
	end

	// sums and the decisions that need no more
	always_comb begin
		d2 = SW'(st_s2.pqa) + SW'(st_s2.pqb);
		r2 = SW'(st_s2.pr);
		q  = SW'(st_s2.pdd) + SW'(st_s2.pee);
		p  = SW'(st_s2.pp1) + SW'(st_s2.pp2);
		de = SW'(st_s2.pux) + SW'(st_s2.puy);
		cr = SW'(st_s2.pc1) - SW'(st_s2.pc2);

		n3.bad   = (st_s2.op == OP_UNUSED);
		n3.defer = 1'b0;
		n3.cr    = cr[CRW-1:0];
		n3.r2    = r2[R2W-1:0];
		n3.q     = q[QW-1:0];
		case (st_s2.op)
			OP_PT_CIRC:   n3.hit = (d2 < r2);
			OP_CIRC_CIRC: n3.hit = !(r2 < d2);
			OP_CIRC_RECT: n3.hit = !(r2 < d2);
			OP_PT_RECT:   n3.hit = st_s2.quick;
			OP_RECT_RECT: n3.hit = st_s2.quick;
			OP_SEG_RECT:  n3.hit = st_s2.okx && st_s2.oky
				&& (st_s2.par || ((st_s2.k1 <= st_s2.k2) && (st_s2.k3 <= st_s2.k4)));
			OP_SEG_CIRC: begin
				if (p <= SW'(0)) begin
					n3.hit = (d2 < r2);
				end else if (p >= q) begin
					n3.hit = (de < r2);
				end else begin
					n3.hit   = 1'b0;
					n3.defer = 1'b1;
				end
			end
			default:      n3.hit = 1'b0;
		endcase
	end

	// split products for the perpendicular distance test
	always_comb begin
		hi_c     = st_s3.cr[CRW-1:LW];
		lo_c     = st_s3.cr[LW-1:0];
		n4.hit   = st_s3.hit;
		n4.bad   = st_s3.bad;
		n4.defer = st_s3.defer;
		n4.hh    = (2*HW)'(hi_c) * (2*HW)'(hi_c);
		n4.hl    = (HW+LW+1)'(hi_c) * $signed({{HW{1'b0}}, 1'b0, lo_c});
		n4.ll    = (2*LW)'(lo_c) * (2*LW)'(lo_c);
		n4.rql   = (R2W+LW)'(st_s3.r2) * (R2W+LW)'(st_s3.q[LW-1:0]);
		n4.rqh   = (R2W+QW-LW)'(st_s3.r2) * (R2W+QW-LW)'(st_s3.q[QW-1:LW]);
	end

	always_comb begin
		cr2 = (XW'(st_s4.hh) << (2*LW)) + (XW'(st_s4.hl) << (LW+1)) + XW'(st_s4.ll);
		rq  = (XW'(st_s4.rqh) << LW) + XW'(st_s4.rql);
		n_out.bad_opcode = st_s4.bad;
		n_out.hit        = st_s4.defer ? (cr2 < rq) : st_s4.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !qs.empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1      <= n1;
			st_s2      <= n2;
			st_s3      <= n3;
			st_s4      <= n4;
			out_data_q <= n_out;
		end
	end

endmodule

// File: rtl/core/primitive_2d_intersection_unit.sv
`timescale 1ns / 1ps

// One collision query per beat, one result per query, in order. A new query can be taken
// every cycle while the queue is not full; each result passes through the two-entry queue
// behind the classifier, then the four-stage arithmetic pipeline and its output register.
// The arithmetic pipeline and output register stall together when the result is not
// taken; the queue then absorbs up to two further queries before ready drops.
module primitive_2d_intersection_unit import pi2d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	ft_t       f_in, f_out;
	q_status_t qs;
	logic      pop;

	assign in_ready = !qs.full;

	pi2d_front u_front (
		.in_data (in_data),
		.f       (f_in)
	);

	pi2d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid && in_ready),
		.wdata  (f_in),
		.pop    (pop),
		.rdata  (f_out),
		.qs     (qs)
	);

	pi2d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.f         (f_out),
		.qs        (qs),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_bad_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.bad_opcode))
		else $error("hit raised on unused opcode");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !qs.empty)
		else $error("queue empty after an accepted beat");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qs.full |-> !qs.empty)
		else $error("queue full and empty at once");

endmodule
